>>> design/zone_weighted_cost_adjust_core_assert.svh
// assertion helpers for the zone weighted cost adjuster
// both sample on i_clk and are off while i_rst_n is low
`ifndef ZONE_WEIGHTED_COST_ADJUST_CORE_ASSERT_SVH
`define ZONE_WEIGHTED_COST_ADJUST_CORE_ASSERT_SVH

// same-cycle implication
`define ZWCA_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("zwca assertion failed");

// next-cycle implication
`define ZWCA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("zwca assertion failed");

`endif

>>> design/zwca_pkg.sv
// ----------------------------------------------------------------------------
// zwca_pkg
// Shared types and constants of the zone weighted cost adjuster.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package zwca_pkg;

    // operation codes of an input transfer
    localparam logic OP_ADJUST     = 1'b0;
    localparam logic OP_ZONE_WRITE = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_BATTERY_LEVEL    = 3'd0;
    localparam logic [2:0] CFG_BATTERY_KNOWN    = 3'd1;
    localparam logic [2:0] CFG_CRITICAL_LEVEL   = 3'd2;
    localparam logic [2:0] CFG_BASE_PENALTY     = 3'd3;
    localparam logic [2:0] CFG_LOW_BATTERY_GAIN = 3'd4;
    localparam logic [2:0] CFG_ZONE_COUNT       = 3'd5;

    localparam logic [9:0]  RST_BATTERY_LEVEL    = 10'd1000;
    localparam logic        RST_BATTERY_KNOWN    = 1'b0;
    localparam logic [9:0]  RST_CRITICAL_LEVEL   = 10'd200;
    localparam logic [15:0] RST_BASE_PENALTY     = 16'd2560;
    localparam logic [15:0] RST_LOW_BATTERY_GAIN = 16'd512;
    localparam logic [3:0]  RST_ZONE_COUNT       = 4'd0;

    localparam logic [15:0] ONE_Q8     = 16'd256;
    localparam logic [7:0]  FREE_LIMIT = 8'd253;
    localparam logic [7:0]  COST_CAP   = 8'd252;
    localparam logic [9:0]  FULL_LEVEL = 10'd1000;

    typedef struct packed {
        logic [9:0]  battery_level;
        logic        battery_known;
        logic [9:0]  critical_level;
        logic [15:0] base_penalty;
        logic [15:0] low_battery_gain;
        logic [3:0]  zone_count;
    } t_cfg;

    // control and narrow payload of one item travelling down the chain
    typedef struct packed {
        logic        valid;
        logic        op;
        logic        hit;
        logic [2:0]  idx;
        logic [2:0]  slot;
        logic [7:0]  cost;
        logic [15:0] factor;   // zone factor on writes, lookups: match or ONE_Q8
    } t_tag;

endpackage

`default_nettype wire

>>> design/zwca_in_if.sv
// ----------------------------------------------------------------------------
// zwca_in_if
// Input channel: cell lookups and zone table writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface zwca_in_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [7:0]            cell_cost;
    logic [COORD_BITS-1:0] cell_col;
    logic [COORD_BITS-1:0] cell_row;
    logic [2:0]            zone_slot;
    logic [COORD_BITS-1:0] zone_col_min;
    logic [COORD_BITS-1:0] zone_col_max;
    logic [COORD_BITS-1:0] zone_row_min;
    logic [COORD_BITS-1:0] zone_row_max;
    logic [15:0]           zone_factor;

    modport source (
        output valid, op, cell_cost, cell_col, cell_row, zone_slot,
               zone_col_min, zone_col_max, zone_row_min, zone_row_max, zone_factor,
        input  ready
    );
    modport sink (
        input  valid, op, cell_cost, cell_col, cell_row, zone_slot,
               zone_col_min, zone_col_max, zone_row_min, zone_row_max, zone_factor,
        output ready
    );
endinterface

`default_nettype wire

>>> design/zwca_out_if.sv
// ----------------------------------------------------------------------------
// zwca_out_if
// Output channel: adjusted cell cost and zone match.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface zwca_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] adjusted_cost;
    logic       zone_hit;
    logic [2:0] zone_index;

    modport source (output valid, adjusted_cost, zone_hit, zone_index, input ready);
    modport sink   (input valid, adjusted_cost, zone_hit, zone_index, output ready);
endinterface

`default_nettype wire

>>> design/zone_weighted_cost_adjust_core.sv
// pipeline: one register stage per zone cell, then the two multiply stages and the
// output register
// throughput: one transfer per cycle, the whole zone-cell chain steps together and
// holds while a result waits at the output
// reset: configuration to defaults and pipeline emptied; the zone table is not cleared
`timescale 1ns / 1ps
`default_nettype none

// ----------------------------------------------------------------------------
// zone_weighted_cost_adjust_core
// Cost map cell adjuster with a chain of zone cells and an energy penalty stage.
// ----------------------------------------------------------------------------
module zone_weighted_cost_adjust_core #(
    parameter int MAX_ZONES  = 8,
    parameter int COORD_BITS = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    zwca_in_if.sink          i_in,
    zwca_out_if.source       o_out
);

    localparam int CB = COORD_BITS;

    zwca_pkg::t_cfg  r_cfg;
    zwca_pkg::t_tag  w_head_tag;
    zwca_pkg::t_tag  w_tag [MAX_ZONES+1];
    logic [CB-1:0]   w_col [MAX_ZONES+1];
    logic [CB-1:0]   w_row [MAX_ZONES+1];
    logic [4*CB-1:0] w_bnd [MAX_ZONES+1];
    logic            w_en;
    logic            w_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.battery_level    <= zwca_pkg::RST_BATTERY_LEVEL;
            r_cfg.battery_known    <= zwca_pkg::RST_BATTERY_KNOWN;
            r_cfg.critical_level   <= zwca_pkg::RST_CRITICAL_LEVEL;
            r_cfg.base_penalty     <= zwca_pkg::RST_BASE_PENALTY;
            r_cfg.low_battery_gain <= zwca_pkg::RST_LOW_BATTERY_GAIN;
            r_cfg.zone_count       <= zwca_pkg::RST_ZONE_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                zwca_pkg::CFG_BATTERY_LEVEL:    r_cfg.battery_level    <= i_cfg_data[9:0];
                zwca_pkg::CFG_BATTERY_KNOWN:    r_cfg.battery_known    <= i_cfg_data[0];
                zwca_pkg::CFG_CRITICAL_LEVEL:   r_cfg.critical_level   <= i_cfg_data[9:0];
                zwca_pkg::CFG_BASE_PENALTY:     r_cfg.base_penalty     <= i_cfg_data;
                zwca_pkg::CFG_LOW_BATTERY_GAIN: r_cfg.low_battery_gain <= i_cfg_data;
                zwca_pkg::CFG_ZONE_COUNT:       r_cfg.zone_count       <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // whole pipeline advances unless a result is stuck at the output
    assign w_en       = !w_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    always_comb begin
        w_head_tag        = '0;
        w_head_tag.valid  = i_in.valid;
        w_head_tag.op     = i_in.op;
        w_head_tag.slot   = i_in.zone_slot;
        w_head_tag.cost   = i_in.cell_cost;
        w_head_tag.factor = (i_in.op == zwca_pkg::OP_ZONE_WRITE) ? i_in.zone_factor
                                                                 : zwca_pkg::ONE_Q8;
    end

    assign w_tag[0] = w_head_tag;
    assign w_col[0] = i_in.cell_col;
    assign w_row[0] = i_in.cell_row;
    assign w_bnd[0] = {i_in.zone_row_max, i_in.zone_row_min,
                       i_in.zone_col_max, i_in.zone_col_min};

    for (genvar g = 0; g < MAX_ZONES; g++) begin : g_cell
        zwca_cell #(
            .IDX        (g),
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (w_en),
            .i_zone_count (r_cfg.zone_count),
            .i_tag        (w_tag[g]),
            .i_col        (w_col[g]),
            .i_row        (w_row[g]),
            .i_bnd        (w_bnd[g]),
            .o_tag        (w_tag[g+1]),
            .o_col        (w_col[g+1]),
            .o_row        (w_row[g+1]),
            .o_bnd        (w_bnd[g+1])
        );
    end

    zwca_cost u_cost (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_en),
        .i_cfg           (r_cfg),
        .i_tag           (w_tag[MAX_ZONES]),
        .o_valid         (w_out_valid),
        .o_adjusted_cost (o_out.adjusted_cost),
        .o_zone_hit      (o_out.zone_hit),
        .o_zone_index    (o_out.zone_index)
    );

    assign o_out.valid = w_out_valid;

`include "zone_weighted_cost_adjust_core_assert.svh"

    `ZWCA_ASSERT_IMPLY(a_index_zero_on_miss, o_out.valid && !o_out.zone_hit, o_out.zone_index == 3'd0)
    `ZWCA_ASSERT_IMPLY(a_index_in_table, o_out.valid && o_out.zone_hit, int'(o_out.zone_index) < MAX_ZONES)
    `ZWCA_ASSERT_IMPLY(a_ready_follows_output, 1'b1, i_in.ready == (!o_out.valid || o_out.ready))
    `ZWCA_ASSERT_NEXT(a_stalled_result_kept, o_out.valid && !o_out.ready, o_out.valid)

endmodule

`default_nettype wire

>>> design/zwca_cell.sv
// ----------------------------------------------------------------------------
// zwca_cell
// One zone slot: holds its bounds and factor, matches or stores the passing item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zwca_cell #(
    parameter int IDX        = 0,
    parameter int COORD_BITS = 12
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic [3:0]              i_zone_count,
    input  wire zwca_pkg::t_tag          i_tag,
    input  wire logic [COORD_BITS-1:0]   i_col,
    input  wire logic [COORD_BITS-1:0]   i_row,
    input  wire logic [4*COORD_BITS-1:0] i_bnd,
    output zwca_pkg::t_tag               o_tag,
    output logic [COORD_BITS-1:0]        o_col,
    output logic [COORD_BITS-1:0]        o_row,
    output logic [4*COORD_BITS-1:0]      o_bnd
);

    localparam int CB = COORD_BITS;

    zwca_pkg::t_tag        r_tag, n_tag;
    logic [CB-1:0]         r_col, r_row;
    logic [4*CB-1:0]       r_bnd;
    logic [4*CB-1:0]       r_zone;     // {row_max, row_min, col_max, col_min}
    logic [15:0]           r_factor;
    logic                  w_active;
    logic                  w_inside;
    logic                  w_write;

    assign w_active = IDX < int'(i_zone_count);
    assign w_write  = i_tag.valid && (i_tag.op == zwca_pkg::OP_ZONE_WRITE)
                      && (int'(i_tag.slot) == IDX);
    assign w_inside = (i_col >= r_zone[CB-1:0])      && (i_col <= r_zone[2*CB-1:CB])
                   && (i_row >= r_zone[3*CB-1:2*CB]) && (i_row <= r_zone[4*CB-1:3*CB]);

    always_comb begin
        n_tag = i_tag;
        // first active match wins, later cells leave it alone
        if (i_tag.op == zwca_pkg::OP_ADJUST && !i_tag.hit && w_active && w_inside) begin
            n_tag.hit    = 1'b1;
            n_tag.idx    = 3'(IDX);
            n_tag.factor = r_factor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
        end else if (i_en) begin
            r_tag <= n_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_col <= i_col;
            r_row <= i_row;
            r_bnd <= i_bnd;
            if (w_write) begin
                r_zone   <= i_bnd;
                r_factor <= i_tag.factor;
            end
        end
    end

    assign o_tag = r_tag;
    assign o_col = r_col;
    assign o_row = r_row;
    assign o_bnd = r_bnd;

endmodule

`default_nettype wire

>>> design/zwca_cost.sv
// ----------------------------------------------------------------------------
// zwca_cost
// Penalty multiply, battery scaling and saturation, with the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module zwca_cost (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire zwca_pkg::t_cfg i_cfg,
    input  wire zwca_pkg::t_tag i_tag,
    output logic                o_valid,
    output logic [7:0]          o_adjusted_cost,
    output logic                o_zone_hit,
    output logic [2:0]          o_zone_index
);

    zwca_pkg::t_tag r_a_tag, r_b_tag;
    logic [31:0]    r_a_prod;
    logic [23:0]    r_b_pen;
    logic           r_out_valid;
    logic [7:0]     r_out_cost;
    logic           r_out_hit;
    logic [2:0]     r_out_idx;

    logic [15:0]    w_extra;
    logic [31:0]    w_prod;
    logic [47:0]    w_scaled;
    logic [9:0]     w_level;
    logic           w_critical;
    logic [23:0]    n_pen;
    logic [8:0]     w_sum;
    logic [7:0]     n_cost;

    assign w_extra = (i_tag.factor > zwca_pkg::ONE_Q8) ? i_tag.factor - zwca_pkg::ONE_Q8
                                                       : 16'd0;
    assign w_prod  = {16'd0, w_extra} * {16'd0, i_cfg.base_penalty};

    // unknown battery counts as full
    assign w_level    = i_cfg.battery_known ? i_cfg.battery_level : zwca_pkg::FULL_LEVEL;
    assign w_critical = w_level < i_cfg.critical_level;
    assign w_scaled   = {16'd0, r_a_prod} * {32'd0, i_cfg.low_battery_gain};
    assign n_pen      = w_critical ? w_scaled[47:24] : {8'd0, r_a_prod[31:16]};

    assign w_sum = {1'b0, r_b_tag.cost} + {1'b0, r_b_pen[7:0]};

    always_comb begin
        if (r_b_tag.cost >= zwca_pkg::FREE_LIMIT) begin
            n_cost = r_b_tag.cost;
        end else if (r_b_pen >= 24'(zwca_pkg::COST_CAP) || w_sum > 9'(zwca_pkg::COST_CAP)) begin
            n_cost = zwca_pkg::COST_CAP;
        end else begin
            n_cost = w_sum[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag.valid <= 1'b0;
            r_b_tag.valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else if (i_en) begin
            r_a_tag     <= i_tag;
            r_b_tag     <= r_a_tag;
            // zone writes end here without a result
            r_out_valid <= r_b_tag.valid && (r_b_tag.op == zwca_pkg::OP_ADJUST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_prod   <= w_prod;
            r_b_pen    <= n_pen;
            r_out_cost <= n_cost;
            r_out_hit  <= r_b_tag.hit;
            r_out_idx  <= r_b_tag.idx;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_adjusted_cost = r_out_cost;
    assign o_zone_hit      = r_out_hit;
    assign o_zone_index    = r_out_idx;

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the zone weighted cost adjuster: cell lookups and
// zone table writes go in over a valid/ready channel with random gaps, every
// adjusted cost is predicted from a local copy of the zone table and of the
// registers, and compared field by field as it comes out under random stalls.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_ZONES      = 8;
    localparam int COORD_BITS     = 12;
    localparam int PIPE_LATENCY   = MAX_ZONES + 3;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic [COORD_BITS-1:0] col_min;
        logic [COORD_BITS-1:0] col_max;
        logic [COORD_BITS-1:0] row_min;
        logic [COORD_BITS-1:0] row_max;
        logic [15:0]           factor;
    } t_zone_rec;

    typedef struct packed {
        logic                  op;
        logic [7:0]            cost;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [2:0]            slot;
        logic [COORD_BITS-1:0] col_min;
        logic [COORD_BITS-1:0] col_max;
        logic [COORD_BITS-1:0] row_min;
        logic [COORD_BITS-1:0] row_max;
        logic [15:0]           factor;
    } t_stream_item;

    typedef struct packed {
        logic [7:0] cost;
        logic       hit;
        logic [2:0] idx;
    } t_cost_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    zwca_in_if #(.COORD_BITS(COORD_BITS)) in_ch ();
    zwca_out_if out_ch ();

    zone_weighted_cost_adjust_core #(
        .MAX_ZONES (MAX_ZONES),
        .COORD_BITS(COORD_BITS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_ch),
        .o_out     (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    zwca_pkg::t_cfg cfg_model;
    t_zone_rec      zone_store [MAX_ZONES];
    t_cost_result   expected_costs [$];
    int unsigned    error_count = 0;
    int unsigned    quiet_cycles = 0;
    bit             no_idle = 1'b0;
    bit             hold_request = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic add_pending(input t_cost_result res);
        expected_costs.insert(expected_costs.size(), res);
    endtask

    function automatic t_cost_result predict_cost(input logic [7:0] cost,
                                                  input logic [COORD_BITS-1:0] col,
                                                  input logic [COORD_BITS-1:0] row);
        t_cost_result      res;
        int unsigned       active;
        logic [15:0]       factor;
        logic [9:0]        level;
        longint unsigned   prod;
        longint unsigned   penalty;
        active = (cfg_model.zone_count > MAX_ZONES) ? MAX_ZONES : 32'(cfg_model.zone_count);
        factor = zwca_pkg::ONE_Q8;
        res.cost = cost;
        res.hit = 1'b0;
        res.idx = '0;
        for (int i = 0; i < active; i++) begin
            if (!res.hit && col >= zone_store[i].col_min && col <= zone_store[i].col_max &&
                row >= zone_store[i].row_min && row <= zone_store[i].row_max) begin
                res.hit = 1'b1;
                res.idx = i[2:0];
                factor = zone_store[i].factor;
            end
        end
        if (cost < zwca_pkg::FREE_LIMIT) begin
            level = cfg_model.battery_known ? cfg_model.battery_level : zwca_pkg::FULL_LEVEL;
            penalty = 0;
            if (factor > zwca_pkg::ONE_Q8) begin
                prod = 64'(factor - zwca_pkg::ONE_Q8) * 64'(cfg_model.base_penalty);
                if (level < cfg_model.critical_level)
                    penalty = (prod * 64'(cfg_model.low_battery_gain)) >> 24;
                else
                    penalty = prod >> 16;
            end
            if (penalty >= zwca_pkg::COST_CAP || 64'(cost) + penalty > zwca_pkg::COST_CAP)
                res.cost = zwca_pkg::COST_CAP;
            else
                res.cost = cost + penalty[7:0];
        end
        return res;
    endfunction

    function automatic t_stream_item lookup_item(input int cost, input int col, input int row);
        t_stream_item it;
        it = '0;
        it.op = zwca_pkg::OP_ADJUST;
        it.cost = cost[7:0];
        it.col = col[COORD_BITS-1:0];
        it.row = row[COORD_BITS-1:0];
        return it;
    endfunction

    function automatic t_stream_item zone_item(input int slot, input int cmin, input int cmax,
                                               input int rmin, input int rmax, input int f);
        t_stream_item it;
        it = '0;
        it.op = zwca_pkg::OP_ZONE_WRITE;
        it.slot = slot[2:0];
        it.col_min = cmin[COORD_BITS-1:0];
        it.col_max = cmax[COORD_BITS-1:0];
        it.row_min = rmin[COORD_BITS-1:0];
        it.row_max = rmax[COORD_BITS-1:0];
        it.factor = f[15:0];
        return it;
    endfunction

    // mostly lookups aimed into the current zones, with zone rewrites mixed in
    function automatic t_stream_item random_item();
        t_stream_item it;
        t_zone_rec    z;
        int unsigned  pick;
        int unsigned  lo;
        it.cost = 8'($urandom_range(0, 255));
        it.col = COORD_BITS'($urandom);
        it.row = COORD_BITS'($urandom);
        it.slot = 3'($urandom);
        it.col_min = COORD_BITS'($urandom);
        it.col_max = COORD_BITS'($urandom);
        it.row_min = COORD_BITS'($urandom);
        it.row_max = COORD_BITS'($urandom);
        it.factor = 16'($urandom);
        if ($urandom_range(0, 99) < 15) begin
            it.op = zwca_pkg::OP_ZONE_WRITE;
            pick = $urandom_range(0, 9);
            case (pick)
                0: begin
                    // inverted on one axis, matches nothing
                    it.col_min = COORD_BITS'($urandom_range(1, 4095));
                    it.col_max = COORD_BITS'($urandom_range(0, it.col_min - 1));
                end
                1: begin
                    it.col_min = '0;
                    it.col_max = '1;
                    it.row_min = '0;
                    it.row_max = '1;
                end
                2: begin
                    it.col_max = it.col_min;
                    it.row_max = it.row_min;
                end
                default: begin
                    lo = $urandom_range(0, 4095);
                    it.col_min = COORD_BITS'(lo);
                    lo = lo + $urandom_range(0, 700);
                    it.col_max = COORD_BITS'((lo > 4095) ? 4095 : lo);
                    lo = $urandom_range(0, 4095);
                    it.row_min = COORD_BITS'(lo);
                    lo = lo + $urandom_range(0, 700);
                    it.row_max = COORD_BITS'((lo > 4095) ? 4095 : lo);
                end
            endcase
            pick = $urandom_range(0, 9);
            case (pick)
                0: it.factor = 16'($urandom_range(0, 255));
                1: it.factor = zwca_pkg::ONE_Q8;
                2: it.factor = 16'($urandom);
                3: it.factor = 16'hFFFF;
                default: it.factor = 16'($urandom_range(257, 1200));
            endcase
        end else begin
            it.op = zwca_pkg::OP_ADJUST;
            if ($urandom_range(0, 99) < 15)
                it.cost = 8'($urandom_range(245, 255));
            if ($urandom_range(0, 99) < 65) begin
                z = zone_store[$urandom_range(0, MAX_ZONES - 1)];
                if (z.col_min <= z.col_max && z.row_min <= z.row_max) begin
                    it.col = COORD_BITS'($urandom_range(z.col_min, z.col_max));
                    it.row = COORD_BITS'($urandom_range(z.row_min, z.row_max));
                end
            end
        end
        return it;
    endfunction

    task automatic send_item(input t_stream_item it);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.op           <= it.op;
        in_ch.cell_cost    <= it.cost;
        in_ch.cell_col     <= it.col;
        in_ch.cell_row     <= it.row;
        in_ch.zone_slot    <= it.slot;
        in_ch.zone_col_min <= it.col_min;
        in_ch.zone_col_max <= it.col_max;
        in_ch.zone_row_min <= it.row_min;
        in_ch.zone_row_max <= it.row_max;
        in_ch.zone_factor  <= it.factor;
        in_ch.valid        <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        if (it.op == zwca_pkg::OP_ZONE_WRITE) begin
            if (it.slot < MAX_ZONES)
                zone_store[it.slot] = '{it.col_min, it.col_max, it.row_min, it.row_max,
                                        it.factor};
        end else begin
            add_pending(predict_cost(it.cost, it.col, it.row));
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            zwca_pkg::CFG_BATTERY_LEVEL:    cfg_model.battery_level    = data[9:0];
            zwca_pkg::CFG_BATTERY_KNOWN:    cfg_model.battery_known    = data[0];
            zwca_pkg::CFG_CRITICAL_LEVEL:   cfg_model.critical_level   = data[9:0];
            zwca_pkg::CFG_BASE_PENALTY:     cfg_model.base_penalty     = data;
            zwca_pkg::CFG_LOW_BATTERY_GAIN: cfg_model.low_battery_gain = data;
            zwca_pkg::CFG_ZONE_COUNT:       cfg_model.zone_count       = data[3:0];
            default: ;
        endcase
    endtask

    // zone writes give no result, so wait out the pipe after the last result
    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_costs.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic random_settings();
        int unsigned pick;
        write_reg(zwca_pkg::CFG_BATTERY_LEVEL, 16'($urandom_range(0, 1000)));
        write_reg(zwca_pkg::CFG_BATTERY_KNOWN, 16'($urandom_range(0, 1)));
        write_reg(zwca_pkg::CFG_CRITICAL_LEVEL, 16'($urandom_range(0, 1000)));
        pick = $urandom_range(0, 9);
        case (pick)
            0: write_reg(zwca_pkg::CFG_BASE_PENALTY, 16'd0);
            1: write_reg(zwca_pkg::CFG_BASE_PENALTY, 16'hFFFF);
            2: write_reg(zwca_pkg::CFG_BASE_PENALTY, 16'($urandom));
            default: write_reg(zwca_pkg::CFG_BASE_PENALTY, 16'($urandom_range(0, 3000)));
        endcase
        pick = $urandom_range(0, 9);
        case (pick)
            0: write_reg(zwca_pkg::CFG_LOW_BATTERY_GAIN, 16'd0);
            1: write_reg(zwca_pkg::CFG_LOW_BATTERY_GAIN, 16'hFFFF);
            2: write_reg(zwca_pkg::CFG_LOW_BATTERY_GAIN, 16'($urandom));
            default: write_reg(zwca_pkg::CFG_LOW_BATTERY_GAIN, 16'($urandom_range(0, 1024)));
        endcase
        pick = $urandom_range(0, 9);
        case (pick)
            0: write_reg(zwca_pkg::CFG_ZONE_COUNT, 16'd0);
            1: write_reg(zwca_pkg::CFG_ZONE_COUNT, 16'($urandom_range(9, 15)));
            default: write_reg(zwca_pkg::CFG_ZONE_COUNT, 16'($urandom_range(1, MAX_ZONES)));
        endcase
    endtask

    // no zones active yet, cost and coordinate extremes
    task automatic test_reset_defaults();
        send_item(lookup_item(0, 0, 0));
        send_item(lookup_item(255, 4095, 4095));
        send_item(lookup_item(253, 0, 4095));
        send_item(lookup_item(252, 4095, 0));
    endtask

    // every slot is loaded before zone_count opens any of them
    task automatic test_zone_priority();
        send_item(zone_item(0, 100, 199, 100, 199, 512));
        send_item(zone_item(1, 300, 200, 0, 4095, 16'hFFFF));
        send_item(zone_item(2, 0, 0, 0, 0, 16'hFFFF));
        send_item(zone_item(3, 4095, 4095, 4095, 4095, 0));
        send_item(zone_item(4, 150, 400, 150, 400, 256));
        send_item(zone_item(5, 1000, 2000, 1000, 2000, 300));
        send_item(zone_item(6, 3000, 3500, 0, 4095, 16'hAAAA));
        send_item(zone_item(7, 0, 4095, 0, 4095, 16'h5555));
        wait_idle();
        write_reg(zwca_pkg::CFG_ZONE_COUNT, 16'(MAX_ZONES));
        send_item(lookup_item(0, 100, 100));
        send_item(lookup_item(100, 150, 150));
        send_item(lookup_item(250, 250, 250));
        send_item(lookup_item(252, 0, 0));
        send_item(lookup_item(10, 4095, 4095));
        send_item(lookup_item(254, 1500, 1500));
        send_item(lookup_item(7, 3200, 17));
        send_item(lookup_item(251, 2048, 4095));
    endtask

    task automatic test_battery_and_limits();
        wait_idle();
        write_reg(zwca_pkg::CFG_BATTERY_KNOWN, 16'd1);
        write_reg(zwca_pkg::CFG_BATTERY_LEVEL, 16'd0);
        write_reg(zwca_pkg::CFG_CRITICAL_LEVEL, 16'd1000);
        write_reg(zwca_pkg::CFG_BASE_PENALTY, 16'hFFFF);
        write_reg(zwca_pkg::CFG_LOW_BATTERY_GAIN, 16'hFFFF);
        send_item(lookup_item(0, 1000, 1000));
        wait_idle();
        // critical but with zero gain
        write_reg(zwca_pkg::CFG_LOW_BATTERY_GAIN, 16'd0);
        send_item(lookup_item(100, 1000, 1000));
        wait_idle();
        // unknown battery counts as full even with level 0
        write_reg(zwca_pkg::CFG_BATTERY_KNOWN, 16'd0);
        send_item(lookup_item(100, 1000, 1000));
        wait_idle();
        write_reg(zwca_pkg::CFG_BATTERY_KNOWN, 16'd1);
        write_reg(zwca_pkg::CFG_BATTERY_LEVEL, 16'd1000);
        write_reg(zwca_pkg::CFG_CRITICAL_LEVEL, 16'd0);
        write_reg(zwca_pkg::CFG_BASE_PENALTY, 16'd0);
        write_reg(zwca_pkg::CFG_ZONE_COUNT, 16'd15);
        send_item(lookup_item(200, 4095, 0));
        wait_idle();
        write_reg(zwca_pkg::CFG_ZONE_COUNT, 16'd1);
        send_item(lookup_item(30, 1500, 1500));
    endtask

    // receiver holds off long while the sender keeps offering
    task automatic test_backpressure();
        wait_idle();
        random_settings();
        no_idle = 1'b1;
        hold_request = 1'b1;
        repeat (60) send_item(random_item());
        no_idle = 1'b0;
    endtask

    task automatic test_drain_pause();
        wait_idle();
        random_settings();
        repeat (30) send_item(random_item());
        // sender stops until every result is back, no settings change
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_costs.size() != 0) @(posedge i_clk);
        repeat (30) send_item(random_item());
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            random_settings();
            no_idle = (ph == 3);
            repeat (120) send_item(random_item());
            no_idle = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_cost_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_costs.size() == 0) begin
                report_mismatch("result with none pending", out_ch.adjusted_cost, 0);
            end else begin
                want = expected_costs.pop_front();
                if (out_ch.adjusted_cost !== want.cost)
                    report_mismatch("adjusted_cost", out_ch.adjusted_cost, want.cost);
                if (out_ch.zone_hit !== want.hit)
                    report_mismatch("zone_hit", out_ch.zone_hit, want.hit);
                if (out_ch.zone_index !== want.idx)
                    report_mismatch("zone_index", out_ch.zone_index, want.idx);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver: random stall per result, or one long hold when asked
    initial begin
        int unsigned hold;
        @(posedge i_rst_n);
        forever begin
            if (hold_request) begin
                hold = LONG_HOLD;
                hold_request = 1'b0;
            end else begin
                hold = no_idle ? 0 : $urandom_range(0, 8);
            end
            if (hold > 0) begin
                @(negedge i_clk);
                out_ch.ready <= 1'b0;
                repeat (hold - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    initial begin
        in_ch.valid        = 1'b0;
        in_ch.op           = zwca_pkg::OP_ADJUST;
        in_ch.cell_cost    = '0;
        in_ch.cell_col     = '0;
        in_ch.cell_row     = '0;
        in_ch.zone_slot    = '0;
        in_ch.zone_col_min = '0;
        in_ch.zone_col_max = '0;
        in_ch.zone_row_min = '0;
        in_ch.zone_row_max = '0;
        in_ch.zone_factor  = '0;
        out_ch.ready       = 1'b0;
        cfg_model = '{battery_level: zwca_pkg::RST_BATTERY_LEVEL,
                      battery_known: zwca_pkg::RST_BATTERY_KNOWN,
                      critical_level: zwca_pkg::RST_CRITICAL_LEVEL,
                      base_penalty: zwca_pkg::RST_BASE_PENALTY,
                      low_battery_gain: zwca_pkg::RST_LOW_BATTERY_GAIN,
                      zone_count: zwca_pkg::RST_ZONE_COUNT};
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_zone_priority();
        test_battery_and_limits();
        test_backpressure();
        test_drain_pause();
        test_random_traffic();
        wait_idle();

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/zwca_pkg.sv
design/zwca_in_if.sv
design/zwca_out_if.sv
design/zwca_cell.sv
design/zwca_cost.sv
design/zone_weighted_cost_adjust_core.sv
bench/testbench.sv
